>>> src/swd_pkg.sv
// Shared types, constants and codes for the swing direction detector.
package swd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int DATA_W       = 16;
	localparam int SAMPLE_SHIFT = DATA_W - SAMPLE_WIDTH;
	localparam int ABS_W        = 15;
	localparam int SQ_W         = 29;
	localparam int MAG_W        = 30;
	localparam int PROD_W       = 30;
	localparam int MUL_W        = 18;
	localparam int CLS_W        = 23;
	localparam int GAIN_W       = 10;
	localparam int GAIN_SHIFT   = 10;
	localparam int HOLD_W       = 16;
	localparam int CNT_W        = 8;
	localparam int RATIO_W      = 8;
	localparam int NUM_AXES     = 3;
	localparam int AXIS_W       = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 30;

	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_RIGHT = 3'd1,
		DIR_LEFT  = 3'd2,
		DIR_UP    = 3'd3,
		DIR_DOWN  = 3'd4
	} dir_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_CAPTURE  = 2'd1,
		PH_COOLDOWN = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_TH   = 3'd0,
		REG_RELEASE_TH = 3'd1,
		REG_COOLDOWN   = 3'd2,
		REG_GAIN       = 3'd3,
		REG_MIN_CAP    = 3'd4,
		REG_MAX_CAP    = 3'd5,
		REG_RATIO_NUM  = 3'd6,
		REG_RATIO_DEN  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [MAG_W-1:0]   start_threshold;
		logic [MAG_W-1:0]   release_threshold;
		logic [HOLD_W-1:0]  cooldown_length;
		logic [GAIN_W-1:0]  smoothing_gain;
		logic [CNT_W-1:0]   min_capture;
		logic [CNT_W-1:0]   max_capture;
		logic [RATIO_W-1:0] ratio_numerator;
		logic [RATIO_W-1:0] ratio_denominator;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_threshold:   30'd1500000,
		release_threshold: 30'd500000,
		cooldown_length:   16'd250,
		smoothing_gain:    10'd3,
		min_capture:       8'd4,
		max_capture:       8'd25,
		ratio_numerator:   8'd10,
		ratio_denominator: 8'd7
	};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP,
		OP_SMOOTH,
		OP_UPDATE,
		OP_SQUARE,
		OP_SUM,
		OP_STEP,
		OP_CLS_A,
		OP_CLS_B,
		OP_CLS_C,
		OP_CLS_D,
		OP_CLS_E,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [AXIS_W-1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic seed;
		logic classify;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_PREP,
		ST_SMOOTH,
		ST_UPDATE,
		ST_SQUARE,
		ST_SUM,
		ST_STEP,
		ST_CLS_A,
		ST_CLS_B,
		ST_CLS_C,
		ST_CLS_D,
		ST_CLS_E,
		ST_EMIT
	} ctrl_state_t;

endpackage

>>> src/accel_swing_direction_detector_unit.sv
// Top level of the swing direction detector: config bank, sequencer and datapath.
// The sequencer takes one item at a time and accepts the next only after the result
// of the last is emitted, which waits while the output is stalled; a seeding item skips
// the baseline and swing steps, and a classified swing adds the ratio-test steps. The
// shared multiplier visits each axis in turn and the ratio test reuses it.
// Reset: arst_n clears baselines, swing state and config to defaults, output empty.
module accel_swing_direction_detector_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [swd_pkg::DATA_W-1:0]  accel_x,
	input  logic signed [swd_pkg::DATA_W-1:0]  accel_y,
	input  logic signed [swd_pkg::DATA_W-1:0]  accel_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         direction,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [swd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swd_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import swd_pkg::*;

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	swd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	swd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	swd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.stat      (stat),
		.direction (direction)
	);

endmodule

>>> src/swd_cfg.sv
// Configuration register bank with its write channel.
module swd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [swd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output swd_pkg::cfg_t                     cfg
);
	import swd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_TH:   cfg_q.start_threshold   <= cfg_data[MAG_W-1:0];
				REG_RELEASE_TH: cfg_q.release_threshold <= cfg_data[MAG_W-1:0];
				REG_COOLDOWN:   cfg_q.cooldown_length   <= cfg_data[HOLD_W-1:0];
				REG_GAIN:       cfg_q.smoothing_gain    <= cfg_data[GAIN_W-1:0];
				REG_MIN_CAP:    cfg_q.min_capture       <= cfg_data[CNT_W-1:0];
				REG_MAX_CAP:    cfg_q.max_capture       <= cfg_data[CNT_W-1:0];
				REG_RATIO_NUM:  cfg_q.ratio_numerator   <= cfg_data[RATIO_W-1:0];
				REG_RATIO_DEN:  cfg_q.ratio_denominator <= cfg_data[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> src/swd_ctrl.sv
// Sequencer that steps the datapath through one item and drives the handshakes.
module swd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  swd_pkg::dp_stat_t stat,
	output swd_pkg::dp_cmd_t  cmd
);
	import swd_pkg::*;

	localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

	ctrl_state_t       state_q, state_d;
	logic [AXIS_W-1:0] axis_q, axis_d;
	logic              out_valid_q;
	logic              emit;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WAIT;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd.op   = OP_NONE;
		cmd.axis = axis_q;
		in_ready = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					axis_d  = '0;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.op  = OP_PREP;
				state_d = stat.seed ? ST_EMIT : ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.op  = OP_SMOOTH;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.op  = OP_UPDATE;
				state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.op = OP_SQUARE;
				if (axis_q == AXIS_LAST) begin
					state_d = ST_SUM;
				end else begin
					axis_d  = axis_q + AXIS_W'(1);
					state_d = ST_SMOOTH;
				end
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_STEP;
			end
			ST_STEP: begin
				cmd.op  = OP_STEP;
				state_d = stat.classify ? ST_CLS_A : ST_EMIT;
			end
			ST_CLS_A: begin
				cmd.op  = OP_CLS_A;
				state_d = ST_CLS_B;
			end
			ST_CLS_B: begin
				cmd.op  = OP_CLS_B;
				state_d = ST_CLS_C;
			end
			ST_CLS_C: begin
				cmd.op  = OP_CLS_C;
				state_d = ST_CLS_D;
			end
			ST_CLS_D: begin
				cmd.op  = OP_CLS_D;
				state_d = ST_CLS_E;
			end
			ST_CLS_E: begin
				cmd.op  = OP_CLS_E;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_EMIT;
					emit    = 1'b1;
					state_d = ST_WAIT;
				end
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

endmodule

>>> src/swd_dp.sv
// Datapath: baselines, shared multiplier, swing phase tracking and classification.
module swd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swd_pkg::dp_cmd_t                    cmd,
	input  swd_pkg::cfg_t                       cfg,
	input  logic signed [swd_pkg::DATA_W-1:0]   accel_x,
	input  logic signed [swd_pkg::DATA_W-1:0]   accel_y,
	input  logic signed [swd_pkg::DATA_W-1:0]   accel_z,
	output swd_pkg::dp_stat_t                   stat,
	output logic [2:0]                          direction
);
	import swd_pkg::*;

	function automatic logic [ABS_W-1:0] abs_val(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] neg;
		neg = -v;
		return v[DATA_W-1] ? neg[ABS_W-1:0] : v[ABS_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] sample_ext(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] up;
		up = v <<< SAMPLE_SHIFT;
		return up >>> SAMPLE_SHIFT;
	endfunction

	// algorithm state
	logic signed [DATA_W-1:0] base_q [NUM_AXES];
	phase_t                   phase_q, phase_d;
	logic [HOLD_W-1:0]        holdoff_q, holdoff_d;
	logic [CNT_W-1:0]         len_q, len_d;
	logic [MAG_W-1:0]         pm_q, pm_d;
	logic [MAG_W-1:0]         pp_q, pp_d;
	logic signed [DATA_W-1:0] px_q, px_d;
	logic signed [DATA_W-1:0] py_q, py_d;

	// working registers
	logic signed [DATA_W-1:0] samp_q [NUM_AXES];
	logic signed [DATA_W-1:0] dyn_q  [NUM_AXES];
	logic [SQ_W-1:0]          sq_q   [NUM_AXES];
	logic signed [PROD_W-1:0] prod_q;
	logic [MAG_W-1:0]         plane_q, mag_q;
	logic signed [DATA_W-1:0] cls_x_q, cls_y_q;
	logic [CLS_W-1:0]         keep_q;
	logic                     gtx_q;
	dir_t                     dir_res_q, direction_q;

	logic signed [DATA_W-1:0]          sel_samp, sel_base, base_new;
	logic signed [DATA_W:0]            diff, dyn_diff;
	logic signed [PROD_W-GAIN_SHIFT-1:0] base_sum;
	logic signed [MUL_W-1:0]           mul_a, mul_b;
	logic signed [2*MUL_W-1:0]         prod_full;
	logic [ABS_W-1:0]                  sq_abs, px_abs, py_abs;
	logic [CNT_W-1:0]                  len_inc;
	logic [MAG_W-1:0]                  pm_upd, pp_upd;
	logic signed [DATA_W-1:0]          px_upd, py_upd;
	logic                              classify, cls_load, seed, gty;
	dir_t                              dir_cls;

	assign direction = direction_q;

	assign sel_samp = samp_q[cmd.axis];
	assign sel_base = base_q[cmd.axis];
	assign diff     = {sel_samp[DATA_W-1], sel_samp} - {sel_base[DATA_W-1], sel_base};
	assign base_sum = $signed({{(PROD_W-GAIN_SHIFT-DATA_W){sel_base[DATA_W-1]}}, sel_base})
		+ $signed(prod_q[PROD_W-1:GAIN_SHIFT]);
	assign base_new = base_sum[DATA_W-1:0];
	assign dyn_diff = {sel_samp[DATA_W-1], sel_samp} - {base_new[DATA_W-1], base_new};

	assign sq_abs = abs_val(dyn_q[cmd.axis]);
	assign px_abs = abs_val(cls_x_q);
	assign py_abs = abs_val(cls_y_q);

	assign seed = (base_q[0] == '0) && (base_q[1] == '0) && (base_q[2] == '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SMOOTH: begin
				mul_a = $signed({diff[DATA_W], diff});
				mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.smoothing_gain});
			end
			OP_SQUARE: begin
				mul_a = $signed({{(MUL_W-ABS_W){1'b0}}, sq_abs});
				mul_b = $signed({{(MUL_W-ABS_W){1'b0}}, sq_abs});
			end
			OP_CLS_A: begin
				mul_a = $signed({{(MUL_W-ABS_W){1'b0}}, px_abs});
				mul_b = $signed({{(MUL_W-RATIO_W){1'b0}}, cfg.ratio_denominator});
			end
			OP_CLS_B: begin
				mul_a = $signed({{(MUL_W-ABS_W){1'b0}}, py_abs});
				mul_b = $signed({{(MUL_W-RATIO_W){1'b0}}, cfg.ratio_numerator});
			end
			OP_CLS_C: begin
				mul_a = $signed({{(MUL_W-ABS_W){1'b0}}, py_abs});
				mul_b = $signed({{(MUL_W-RATIO_W){1'b0}}, cfg.ratio_denominator});
			end
			OP_CLS_D: begin
				mul_a = $signed({{(MUL_W-ABS_W){1'b0}}, px_abs});
				mul_b = $signed({{(MUL_W-RATIO_W){1'b0}}, cfg.ratio_numerator});
			end
			default: begin
			end
		endcase
	end

	assign prod_full = mul_a * mul_b;

	// swing phase step
	always_comb begin
		phase_d   = phase_q;
		holdoff_d = holdoff_q;
		len_d     = len_q;
		pm_d      = pm_q;
		pp_d      = pp_q;
		px_d      = px_q;
		py_d      = py_q;
		classify  = 1'b0;
		cls_load  = 1'b0;
		len_inc   = len_q + CNT_W'(1);
		pm_upd    = (mag_q > pm_q) ? mag_q : pm_q;
		pp_upd    = pp_q;
		px_upd    = px_q;
		py_upd    = py_q;
		if (plane_q > pp_q) begin
			pp_upd = plane_q;
			px_upd = dyn_q[0];
			py_upd = dyn_q[1];
		end
		case (phase_q)
			PH_IDLE: begin
				if (mag_q > cfg.start_threshold) begin
					len_d   = '0;
					pm_d    = mag_q;
					pp_d    = plane_q;
					px_d    = dyn_q[0];
					py_d    = dyn_q[1];
					phase_d = PH_CAPTURE;
				end
			end
			PH_CAPTURE: begin
				len_d = len_inc;
				pm_d  = pm_upd;
				pp_d  = pp_upd;
				px_d  = px_upd;
				py_d  = py_upd;
				if ((mag_q < cfg.release_threshold && len_inc >= cfg.min_capture) ||
					len_inc >= cfg.max_capture) begin
					classify  = (pm_upd > cfg.start_threshold) &&
						(len_inc >= cfg.min_capture) && (holdoff_q == '0);
					cls_load  = 1'b1;
					holdoff_d = cfg.cooldown_length;
					phase_d   = PH_COOLDOWN;
					len_d     = '0;
					pm_d      = '0;
					pp_d      = '0;
					px_d      = '0;
					py_d      = '0;
				end
			end
			PH_COOLDOWN: begin
				if (holdoff_q == '0 && mag_q < cfg.release_threshold) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign stat.seed     = seed;
	assign stat.classify = classify;

	assign gty = keep_q > prod_q[CLS_W-1:0];

	always_comb begin
		if (gtx_q) begin
			dir_cls = (!cls_x_q[DATA_W-1] && cls_x_q != '0) ? DIR_RIGHT : DIR_LEFT;
		end else if (gty) begin
			dir_cls = (!cls_y_q[DATA_W-1] && cls_y_q != '0) ? DIR_UP : DIR_DOWN;
		end else begin
			dir_cls = DIR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				base_q[i] <= '0;
			end
			phase_q   <= PH_IDLE;
			holdoff_q <= '0;
			len_q     <= '0;
			pm_q      <= '0;
			pp_q      <= '0;
			px_q      <= '0;
			py_q      <= '0;
		end else begin
			case (cmd.op)
				OP_PREP: begin
					if (holdoff_q != '0) begin
						holdoff_q <= holdoff_q - HOLD_W'(1);
					end
					if (seed) begin
						for (int i = 0; i < NUM_AXES; i++) begin
							base_q[i] <= samp_q[i];
						end
					end
				end
				OP_UPDATE: begin
					base_q[cmd.axis] <= base_new;
				end
				OP_STEP: begin
					phase_q   <= phase_d;
					holdoff_q <= holdoff_d;
					len_q     <= len_d;
					pm_q      <= pm_d;
					pp_q      <= pp_d;
					px_q      <= px_d;
					py_q      <= py_d;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				samp_q[0] <= sample_ext(accel_x);
				samp_q[1] <= sample_ext(accel_y);
				samp_q[2] <= sample_ext(accel_z);
			end
			OP_PREP: begin
				dir_res_q <= DIR_NONE;
			end
			OP_SMOOTH: begin
				prod_q <= prod_full[PROD_W-1:0];
			end
			OP_UPDATE: begin
				dyn_q[cmd.axis] <= {dyn_diff[DATA_W], dyn_diff[DATA_W:2]};
			end
			OP_SQUARE: begin
				sq_q[cmd.axis] <= prod_full[SQ_W-1:0];
			end
			OP_SUM: begin
				plane_q <= MAG_W'(sq_q[0]) + MAG_W'(sq_q[1]);
				mag_q   <= MAG_W'(sq_q[0]) + MAG_W'(sq_q[1]) + MAG_W'(sq_q[2]);
			end
			OP_STEP: begin
				if (cls_load) begin
					cls_x_q <= px_upd;
					cls_y_q <= py_upd;
				end
			end
			OP_CLS_A: begin
				prod_q <= prod_full[PROD_W-1:0];
			end
			OP_CLS_B: begin
				keep_q <= prod_q[CLS_W-1:0];
				prod_q <= prod_full[PROD_W-1:0];
			end
			OP_CLS_C: begin
				gtx_q  <= keep_q > prod_q[CLS_W-1:0];
				prod_q <= prod_full[PROD_W-1:0];
			end
			OP_CLS_D: begin
				keep_q <= prod_q[CLS_W-1:0];
				prod_q <= prod_full[PROD_W-1:0];
			end
			OP_CLS_E: begin
				dir_res_q <= dir_cls;
			end
			OP_EMIT: begin
				direction_q <= dir_res_q;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/swd_chk.sv
// Port-level checker for the swing direction detector and its bind.
module swd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  direction
);
	import swd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(direction))
		else $error("result item changed while stalled");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> direction <= DIR_DOWN)
		else $error("direction code out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("item accepted while previous item in progress");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after accept");

endmodule

bind accel_swing_direction_detector_unit swd_chk u_swd_chk (.*);

>>> sim/tb.sv
// Testbench for the swing direction detector: directed and random swings.
module tb;
	import swd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic signed [DATA_W-1:0] accel_x = '0;
	logic signed [DATA_W-1:0] accel_y = '0;
	logic signed [DATA_W-1:0] accel_z = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  direction;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	accel_swing_direction_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.direction (direction),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// detector state as the block should hold it
	cfg_t            cfg = CFG_RESET;
	int              base_x = 0;
	int              base_y = 0;
	int              base_z = 0;
	phase_t          swing_phase = PH_IDLE;
	logic [HOLD_W-1:0] holdoff = '0;
	logic [CNT_W-1:0]  capture_len = '0;
	longint          peak_mag = 0;
	longint          peak_plane = 0;
	longint          peak_px = 0;
	longint          peak_py = 0;

	dir_t expected_dirs[$];
	int   mismatch_count = 0;
	int   items_sent = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   rx_hold_cycles = 0;

	function automatic int next_baseline(input int b, input int s);
		longint d;
		longint g;
		g = longint'(cfg.smoothing_gain);
		d = longint'(s) - longint'(b);
		return int'(longint'(b) + ((d * g) >>> 10));
	endfunction

	function automatic longint magnitude_of(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	task automatic predict_direction(input int sx, input int sy, input int sz, output dir_t dir);
		longint dx, dy, dz, plane, mag, px, py, num, den, st, rt;
		dir = DIR_NONE;
		if (holdoff != 0)
			holdoff = holdoff - 1'b1;
		if (base_x == 0 && base_y == 0 && base_z == 0) begin
			base_x = sx;
			base_y = sy;
			base_z = sz;
			return;
		end
		base_x = next_baseline(base_x, sx);
		base_y = next_baseline(base_y, sy);
		base_z = next_baseline(base_z, sz);
		dx = (longint'(sx) - longint'(base_x)) >>> 2;
		dy = (longint'(sy) - longint'(base_y)) >>> 2;
		dz = (longint'(sz) - longint'(base_z)) >>> 2;
		plane = magnitude_of(dx) * magnitude_of(dx) + magnitude_of(dy) * magnitude_of(dy);
		mag = plane + magnitude_of(dz) * magnitude_of(dz);
		st = longint'(cfg.start_threshold);
		rt = longint'(cfg.release_threshold);
		case (swing_phase)
			PH_IDLE: begin
				if (mag > st) begin
					capture_len = '0;
					peak_mag = mag;
					peak_plane = plane;
					peak_px = dx;
					peak_py = dy;
					swing_phase = PH_CAPTURE;
				end
			end
			PH_CAPTURE: begin
				capture_len = capture_len + 1'b1;
				if (mag > peak_mag)
					peak_mag = mag;
				if (plane > peak_plane) begin
					peak_plane = plane;
					peak_px = dx;
					peak_py = dy;
				end
				if ((mag < rt && capture_len >= cfg.min_capture) ||
						capture_len >= cfg.max_capture) begin
					if (peak_mag > st && capture_len >= cfg.min_capture && holdoff == 0) begin
						px = magnitude_of(peak_px);
						py = magnitude_of(peak_py);
						num = longint'(cfg.ratio_numerator);
						den = longint'(cfg.ratio_denominator);
						if (px * den > py * num) begin
							if (peak_px > 0)
								dir = DIR_RIGHT;
							else
								dir = DIR_LEFT;
						end else if (py * den > px * num) begin
							if (peak_py > 0)
								dir = DIR_UP;
							else
								dir = DIR_DOWN;
						end
					end
					holdoff = cfg.cooldown_length;
					swing_phase = PH_COOLDOWN;
					capture_len = '0;
					peak_mag = 0;
					peak_plane = 0;
					peak_px = 0;
					peak_py = 0;
				end
			end
			PH_COOLDOWN: begin
				if (holdoff == 0 && mag < rt)
					swing_phase = PH_IDLE;
			end
			default: swing_phase = PH_IDLE;
		endcase
	endtask

	// result side: random stalls, or a counted hold-off
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_ready = 1'b0;
			rx_hold_cycles = rx_hold_cycles - 1;
		end else begin
			out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : check_direction
		dir_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_dirs.size() == 0) begin
				$error("direction: no item expected, actual %0d", direction);
				mismatch_count++;
			end else begin
				want = expected_dirs.pop_front();
				if (direction !== want) begin
					$error("direction: expected %0d, actual %0d", want, direction);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_sample(input logic signed [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] y, input logic signed [DATA_W-1:0] z);
		dir_t d;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		accel_x = x;
		accel_y = y;
		accel_z = z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_direction(int'(accel_x), int'(accel_y), int'(accel_z), d);
		expected_dirs.push_back(d);
		items_sent++;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_dirs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_START_TH:   cfg.start_threshold = val;
			REG_RELEASE_TH: cfg.release_threshold = val;
			REG_COOLDOWN:   cfg.cooldown_length = val[HOLD_W-1:0];
			REG_GAIN:       cfg.smoothing_gain = val[GAIN_W-1:0];
			REG_MIN_CAP:    cfg.min_capture = val[CNT_W-1:0];
			REG_MAX_CAP:    cfg.max_capture = val[CNT_W-1:0];
			REG_RATIO_NUM:  cfg.ratio_numerator = val[RATIO_W-1:0];
			REG_RATIO_DEN:  cfg.ratio_denominator = val[RATIO_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input cfg_t c);
		wait_for_results();
		repeat (4) @(posedge clk);
		write_reg(REG_START_TH, c.start_threshold);
		write_reg(REG_RELEASE_TH, c.release_threshold);
		write_reg(REG_COOLDOWN, CFG_DATA_W'(c.cooldown_length));
		write_reg(REG_GAIN, CFG_DATA_W'(c.smoothing_gain));
		write_reg(REG_MIN_CAP, CFG_DATA_W'(c.min_capture));
		write_reg(REG_MAX_CAP, CFG_DATA_W'(c.max_capture));
		write_reg(REG_RATIO_NUM, CFG_DATA_W'(c.ratio_numerator));
		write_reg(REG_RATIO_DEN, CFG_DATA_W'(c.ratio_denominator));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int spread(input int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	// offset from the current baseline, so swings stand out against it
	task automatic send_offset(input int ox, input int oy, input int oz, input int r);
		send_sample(16'(clamp16(base_x + ox + spread(r))),
				16'(clamp16(base_y + oy + spread(r))),
				16'(clamp16(base_z + oz + spread(r))));
	endtask

	task automatic run_swings(input int n);
		int stop, pick, amp, ox, oy, oz;
		stop = items_sent + n;
		while (items_sent < stop) begin
			pick = int'($urandom_range(0, 19));
			if (pick == 0) begin
				send_sample(16'($urandom), 16'($urandom), 16'($urandom));
			end else if (pick == 1) begin
				repeat (3) send_sample('0, '0, '0);
			end else begin
				amp = int'($urandom_range(1500, 32767));
				ox = spread(amp / 4);
				oy = spread(amp / 4);
				case ($urandom_range(0, 4))
					0: ox = amp;
					1: ox = -amp;
					2: oy = amp;
					3: oy = -amp;
					default: begin
						ox = $urandom_range(0, 1) ? amp : -amp;
						oy = $urandom_range(0, 1) ? amp : -amp;
					end
				endcase
				oz = spread(amp / 2);
				repeat ($urandom_range(0, 3)) send_offset(0, 0, 0, 60);
				repeat ($urandom_range(1, 8)) send_offset(ox, oy, oz, amp / 8);
				repeat ($urandom_range(1, 10)) send_offset(0, 0, 0, 60);
			end
		end
	endtask

	task automatic swing_at(input int x, input int y, input int z);
		repeat (2) send_sample(16'(x), 16'(y), 16'(z));
		repeat (2) send_sample(16'sd1000, 16'sd1000, 16'sd1000);
	endtask

	task automatic test_directed_swings();
		cfg_t c;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		c = CFG_RESET;
		c.cooldown_length = 16'd0;
		c.min_capture = 8'd2;
		set_config(c);
		send_sample('0, '0, '0);
		send_sample('0, '0, '0);
		send_sample(16'sd1000, 16'sd1000, 16'sd1000);
		swing_at(32767, 1000, 1000);
		swing_at(-32768, 1000, 1000);
		swing_at(1000, 32767, 32767);
		swing_at(1000, -32768, 1000);
		swing_at(32767, 32767, -32768);
		send_sample(16'sd1000, 16'sd1000, 16'sd1000);
	endtask

	task automatic test_high_thresholds();
		cfg_t c;
		c.start_threshold = 30'h3FFF_FFFF;
		c.release_threshold = 30'h3FFF_FFFF;
		c.cooldown_length = 16'hFFFF;
		c.smoothing_gain = 10'd0;
		c.min_capture = 8'd255;
		c.max_capture = 8'd255;
		c.ratio_numerator = 8'd255;
		c.ratio_denominator = 8'd255;
		set_config(c);
		tx_idle_pct = 32;
		rx_stall_pct = 32;
		run_swings(200);
	endtask

	task automatic test_reset_config();
		cfg_t c;
		c = CFG_RESET;
		c.cooldown_length = 16'd20;
		set_config(c);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_swings(250);
	endtask

	task automatic test_sender_gaps();
		cfg_t c;
		c.start_threshold = 30'd200000;
		c.release_threshold = 30'd100000;
		c.cooldown_length = 16'd3;
		c.smoothing_gain = 10'd16;
		c.min_capture = 8'd1;
		c.max_capture = 8'd8;
		c.ratio_numerator = 8'd3;
		c.ratio_denominator = 8'd2;
		set_config(c);
		tx_idle_pct = 49;
		rx_stall_pct = 0;
		run_swings(250);
	endtask

	task automatic test_receiver_stalls();
		cfg_t c;
		c.start_threshold = '0;
		c.release_threshold = '0;
		c.cooldown_length = '0;
		c.smoothing_gain = 10'd1023;
		c.min_capture = 8'd1;
		c.max_capture = 8'd255;
		c.ratio_numerator = 8'd1;
		c.ratio_denominator = 8'd1;
		set_config(c);
		tx_idle_pct = 0;
		rx_stall_pct = 49;
		run_swings(250);
	endtask

	task automatic test_zero_limits();
		cfg_t c;
		c = CFG_RESET;
		c.cooldown_length = '0;
		c.min_capture = '0;
		c.max_capture = '0;
		c.ratio_numerator = '0;
		c.ratio_denominator = 8'd1;
		set_config(c);
		tx_idle_pct = 49;
		rx_stall_pct = 0;
		run_swings(250);
	endtask

	task automatic test_inverted_limits();
		cfg_t c;
		c.start_threshold = 30'd1000000;
		c.release_threshold = 30'd800000;
		c.cooldown_length = 16'd2;
		c.smoothing_gain = 10'd100;
		c.min_capture = 8'd10;
		c.max_capture = 8'd5;
		c.ratio_numerator = 8'd1;
		c.ratio_denominator = '0;
		set_config(c);
		tx_idle_pct = 0;
		rx_stall_pct = 49;
		run_swings(250);
	endtask

	task automatic test_backpressure();
		cfg_t c;
		c = CFG_RESET;
		c.cooldown_length = 16'd10;
		set_config(c);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_swings(50);
		rx_hold_cycles = 300;
		run_swings(100);
		wait_for_results();
		tx_idle_pct = 32;
		rx_stall_pct = 32;
		run_swings(100);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed_swings();
		test_high_thresholds();
		test_reset_config();
		test_sender_gaps();
		test_receiver_stalls();
		test_zero_limits();
		test_inverted_limits();
		test_backpressure();
		wait_for_results();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> accel_swing_direction_detector_unit.f
src/swd_pkg.sv
src/swd_cfg.sv
src/swd_ctrl.sv
src/swd_dp.sv
src/accel_swing_direction_detector_unit.sv
src/swd_chk.sv
sim/tb.sv
